// ===== hdl/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and codes for the priority LED blink controller.
// ----------------------------------------------------------------------------
package plc_pkg;

    // input kinds (tuser on the slave side)
    localparam logic FUNC_SET  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // flash modes
    localparam logic [1:0] FLASH_NONE  = 2'd0;
    localparam logic [1:0] FLASH_TIMED = 2'd1;
    localparam logic [1:0] FLASH_HW    = 2'd2;

    // owner code meaning no slot shows
    localparam logic [1:0] NO_OWNER = 2'd3;

    // result status
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_SLOT = 1'b1;

    localparam int COLOUR_W = 24;
    localparam int CHAN_W   = 8;
    localparam int FIELD_TIME_W = 16;

    typedef enum logic [1:0] {
        BLINK_NOP,
        BLINK_TICK,
        BLINK_LOAD
    } t_blink_op;

    typedef struct packed {
        logic       we;
        logic [1:0] addr;
    } t_store_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_SEARCH,
        S_SHOW,
        S_OUT,
        S_RESULT
    } t_state;

endpackage

// ===== hdl/priority_led_blink_controller.sv =====
// ----------------------------------------------------------------------------
// priority_led_blink_controller
// Shares one RGB LED between prioritized request slots, with timed blinking.
// ----------------------------------------------------------------------------
// Each transfer in gives exactly one transfer out. For a millisecond tick, a
// rejected request or a request that only stores its slot, the input is
// registered, then passes the write and output states before the result is
// valid. A request that takes or gives up the LED also passes a show state
// that loads the blink timer; when the shown slot is cleared, the controller
// first walks down the slots in a search state, one lower slot at a time,
// for the next lit one. A sequencer drives that walk through the single read
// port of the slot store, so the block takes one item at a time and holds
// s_axis_tready low until the result has been transferred.
module priority_led_blink_controller #(
    parameter int SLOT_COUNT = 3,
    parameter int TIME_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slot[1:0], color[25:2], flash_mode[27:26], on_ms[43:28], off_ms[59:44]
    input  logic [63:0] s_axis_tdata,
    // func[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], shown_slot[25:24], blinking[26]
    output logic [31:0] m_axis_tdata,
    // status[0]
    output logic [0:0]  m_axis_tuser
);

    localparam int CW = plc_pkg::COLOUR_W;

    plc_pkg::t_state r_state, n_state;

    logic                 r_func;
    logic [1:0]           r_slot;
    logic [CW-1:0]        r_color;
    logic [1:0]           r_mode;
    logic [15:0]          r_on;
    logic [15:0]          r_off;
    logic [1:0]           r_idx, n_idx;
    logic [1:0]           r_owner, n_owner;
    logic                 r_status, n_status;
    logic [31:0]          r_tdata, n_tdata;

    plc_pkg::t_store_wr   w_wr;
    plc_pkg::t_blink_op   w_blink_op;
    logic [1:0]           w_rd_addr;
    logic [CW-1:0]        w_rd_colour;
    logic [TIME_BITS-1:0] w_rd_on;
    logic [TIME_BITS-1:0] w_rd_off;
    logic                 w_blink_active;
    logic                 w_blink_phase_on;
    logic [CW-1:0]        w_blink_colour;

    logic                 w_slot_ok;
    logic                 w_is_attn;
    logic                 w_timed;
    logic [TIME_BITS-1:0] w_on_t;
    logic [TIME_BITS-1:0] w_off_t;
    logic [CW-1:0]        w_colour_adj;
    logic [TIME_BITS-1:0] w_wr_on;
    logic [TIME_BITS-1:0] w_wr_off;
    logic [CW-1:0]        w_shown;

    assign w_slot_ok = ({2'b00, r_slot} < 4'(SLOT_COUNT));
    assign w_is_attn = ({2'b00, r_slot} == 4'(SLOT_COUNT - 1));
    assign w_on_t    = TIME_BITS'(r_on);
    assign w_off_t   = TIME_BITS'(r_off);

    // blink times kept only for timed modes, plus attention slot adjustments
    always_comb begin
        w_timed      = (r_mode == plc_pkg::FLASH_TIMED) || (r_mode == plc_pkg::FLASH_HW);
        w_colour_adj = r_color;
        if (w_is_attn) begin
            if (r_mode == plc_pkg::FLASH_NONE) begin
                w_colour_adj = '0;
            end else if (r_mode == plc_pkg::FLASH_HW && w_on_t != '0 && w_off_t == '0) begin
                w_timed = 1'b0;
            end
        end
        w_wr_on  = w_timed ? w_on_t : '0;
        w_wr_off = w_timed ? w_off_t : '0;
    end

    assign w_rd_addr = (r_state == plc_pkg::S_OUT) ? r_owner : r_idx;

    plc_slot_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .TIME_BITS  (TIME_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_wr),
        .i_wr_colour (w_colour_adj),
        .i_wr_on     (w_wr_on),
        .i_wr_off    (w_wr_off),
        .i_rd_addr   (w_rd_addr),
        .o_rd_colour (w_rd_colour),
        .o_rd_on     (w_rd_on),
        .o_rd_off    (w_rd_off)
    );

    plc_blink #(
        .TIME_BITS (TIME_BITS)
    ) u_blink (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_blink_op),
        .i_colour   (w_rd_colour),
        .i_on       (w_rd_on),
        .i_off      (w_rd_off),
        .o_active   (w_blink_active),
        .o_phase_on (w_blink_phase_on),
        .o_colour   (w_blink_colour)
    );

    always_comb begin
        if (w_blink_active) begin
            w_shown = w_blink_phase_on ? w_blink_colour : '0;
        end else begin
            w_shown = w_rd_colour;  // store reads zero for the no-owner code
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= plc_pkg::S_IDLE;
            r_owner  <= plc_pkg::NO_OWNER;
            r_idx    <= '0;
            r_status <= plc_pkg::STATUS_OK;
        end else begin
            r_state  <= n_state;
            r_owner  <= n_owner;
            r_idx    <= n_idx;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tdata <= n_tdata;
        if (s_axis_tvalid && s_axis_tready) begin
            r_func  <= s_axis_tuser[0];
            r_slot  <= s_axis_tdata[1:0];
            r_color <= s_axis_tdata[25:2];
            r_mode  <= s_axis_tdata[27:26];
            r_on    <= s_axis_tdata[43:28];
            r_off   <= s_axis_tdata[59:44];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_owner    = r_owner;
        n_idx      = r_idx;
        n_status   = r_status;
        n_tdata    = r_tdata;
        w_wr       = '0;
        w_blink_op = plc_pkg::BLINK_NOP;
        case (r_state)
            plc_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = plc_pkg::S_WRITE;
                end
            end
            plc_pkg::S_WRITE: begin
                n_status = plc_pkg::STATUS_OK;
                n_state  = plc_pkg::S_OUT;
                if (r_func == plc_pkg::FUNC_TICK) begin
                    w_blink_op = plc_pkg::BLINK_TICK;
                end else if (!w_slot_ok) begin
                    n_status = plc_pkg::STATUS_BAD_SLOT;
                end else begin
                    w_wr.we   = 1'b1;
                    w_wr.addr = r_slot;
                    if (w_colour_adj != '0) begin
                        if (r_owner == plc_pkg::NO_OWNER || r_slot >= r_owner) begin
                            n_owner = r_slot;
                            n_idx   = r_slot;
                            n_state = plc_pkg::S_SHOW;
                        end
                    end else if (r_slot == r_owner) begin
                        if (r_slot == 2'd0) begin
                            n_owner = plc_pkg::NO_OWNER;
                            n_idx   = plc_pkg::NO_OWNER;
                            n_state = plc_pkg::S_SHOW;
                        end else begin
                            n_idx   = r_slot - 2'd1;
                            n_state = plc_pkg::S_SEARCH;
                        end
                    end
                end
            end
            plc_pkg::S_SEARCH: begin
                // walk down one slot a cycle looking for a lit one
                n_state = plc_pkg::S_SHOW;
                if (w_rd_colour != '0) begin
                    n_owner = r_idx;
                end else if (r_idx == 2'd0) begin
                    n_owner = plc_pkg::NO_OWNER;
                    n_idx   = plc_pkg::NO_OWNER;
                end else begin
                    n_idx   = r_idx - 2'd1;
                    n_state = plc_pkg::S_SEARCH;
                end
            end
            plc_pkg::S_SHOW: begin
                w_blink_op = plc_pkg::BLINK_LOAD;
                n_state    = plc_pkg::S_OUT;
            end
            plc_pkg::S_OUT: begin
                n_tdata = {5'b0, w_blink_active, r_owner,
                           w_shown[7:0], w_shown[15:8], w_shown[23:16]};
                n_state = plc_pkg::S_RESULT;
            end
            plc_pkg::S_RESULT: begin
                if (m_axis_tready) begin
                    n_state = plc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = plc_pkg::S_IDLE;
            end
        endcase
    end

    assign s_axis_tready   = (r_state == plc_pkg::S_IDLE);
    assign m_axis_tvalid   = (r_state == plc_pkg::S_RESULT);
    assign m_axis_tdata    = r_tdata;
    assign m_axis_tuser[0] = r_status;

endmodule

// ===== hdl/plc_slot_store.sv =====
// ----------------------------------------------------------------------------
// plc_slot_store
// Per-slot colour and blink times, one write port and one read port.
// ----------------------------------------------------------------------------
module plc_slot_store #(
    parameter int SLOT_COUNT = 3,
    parameter int TIME_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  plc_pkg::t_store_wr            i_wr,
    input  logic [plc_pkg::COLOUR_W-1:0]  i_wr_colour,
    input  logic [TIME_BITS-1:0]          i_wr_on,
    input  logic [TIME_BITS-1:0]          i_wr_off,
    input  logic [1:0]                    i_rd_addr,
    output logic [plc_pkg::COLOUR_W-1:0]  o_rd_colour,
    output logic [TIME_BITS-1:0]          o_rd_on,
    output logic [TIME_BITS-1:0]          o_rd_off
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [plc_pkg::COLOUR_W-1:0] r_colour [SLOT_COUNT];
    logic [TIME_BITS-1:0]         r_on     [SLOT_COUNT];
    logic [TIME_BITS-1:0]         r_off    [SLOT_COUNT];

    logic [IDX_W+1:0] w_wr_ext;
    logic [IDX_W+1:0] w_rd_ext;
    logic [IDX_W-1:0] w_wr_idx;
    logic [IDX_W-1:0] w_rd_idx;
    logic             w_wr_ok;
    logic             w_rd_ok;

    assign w_wr_ext = (IDX_W+2)'(i_wr.addr);
    assign w_rd_ext = (IDX_W+2)'(i_rd_addr);
    assign w_wr_idx = w_wr_ext[IDX_W-1:0];
    assign w_rd_idx = w_rd_ext[IDX_W-1:0];
    assign w_wr_ok  = ({2'b00, i_wr.addr} < 4'(SLOT_COUNT));
    assign w_rd_ok  = ({2'b00, i_rd_addr} < 4'(SLOT_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_colour[i] <= '0;
                r_on[i]     <= '0;
                r_off[i]    <= '0;
            end
        end else if (i_wr.we && w_wr_ok) begin
            r_colour[w_wr_idx] <= i_wr_colour;
            r_on[w_wr_idx]     <= i_wr_on;
            r_off[w_wr_idx]    <= i_wr_off;
        end
    end

    // slots beyond the store read as empty
    always_comb begin
        o_rd_colour = '0;
        o_rd_on     = '0;
        o_rd_off    = '0;
        if (w_rd_ok) begin
            o_rd_colour = r_colour[w_rd_idx];
            o_rd_on     = r_on[w_rd_idx];
            o_rd_off    = r_off[w_rd_idx];
        end
    end

endmodule

// ===== hdl/plc_blink.sv =====
// ----------------------------------------------------------------------------
// plc_blink
// Blink timer: latched colour and phase lengths, millisecond phase counter.
// ----------------------------------------------------------------------------
module plc_blink #(
    parameter int TIME_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  plc_pkg::t_blink_op            i_op,
    input  logic [plc_pkg::COLOUR_W-1:0]  i_colour,
    input  logic [TIME_BITS-1:0]          i_on,
    input  logic [TIME_BITS-1:0]          i_off,
    output logic                          o_active,
    output logic                          o_phase_on,
    output logic [plc_pkg::COLOUR_W-1:0]  o_colour
);

    logic                         r_active;
    logic                         r_phase_on;
    logic [TIME_BITS-1:0]         r_timer;
    logic [plc_pkg::COLOUR_W-1:0] r_colour;
    logic [TIME_BITS-1:0]         r_on_copy;
    logic [TIME_BITS-1:0]         r_off_copy;

    logic [TIME_BITS-1:0] w_timer_inc;
    logic [TIME_BITS-1:0] w_len;
    logic                 w_can_blink;

    assign w_timer_inc = r_timer + TIME_BITS'(1);
    assign w_len       = r_phase_on ? r_on_copy : r_off_copy;
    assign w_can_blink = (i_colour != '0) && (i_on != '0) && (i_off != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_phase_on <= 1'b0;
            r_timer    <= '0;
            r_colour   <= '0;
            r_on_copy  <= '0;
            r_off_copy <= '0;
        end else begin
            case (i_op)
                plc_pkg::BLINK_TICK: begin
                    if (r_active) begin
                        if (w_timer_inc >= w_len) begin
                            r_phase_on <= !r_phase_on;
                            r_timer    <= '0;
                        end else begin
                            r_timer <= w_timer_inc;
                        end
                    end
                end
                plc_pkg::BLINK_LOAD: begin
                    r_timer <= '0;
                    if (w_can_blink) begin
                        r_active   <= 1'b1;
                        r_phase_on <= 1'b1;
                        r_colour   <= i_colour;
                        r_on_copy  <= i_on;
                        r_off_copy <= i_off;
                    end else begin
                        r_active   <= 1'b0;
                        r_phase_on <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_active   = r_active;
    assign o_phase_on = r_phase_on;
    assign o_colour   = r_colour;

endmodule

// ===== tb/priority_led_blink_controller_test.sv =====
// ----------------------------------------------------------------------------
// priority_led_blink_controller_test
// Self-checking bench for the shared-LED priority and blink controller. A
// short table of hand-picked requests and ticks runs first, then random
// traffic, over half of it ticks, with mostly short blink times. Every
// accepted item updates a behavioral copy of the controller, and each
// result transfer is compared field by field against it, or against the
// table's own values where a table row gives them. Both stream sides idle
// at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module priority_led_blink_controller_test;

    localparam logic [1:0] SLOT_BATTERY = 2'd0;
    localparam logic [1:0] SLOT_NOTIFY  = 2'd1;
    localparam logic [1:0] SLOT_ATTN    = 2'd2;
    localparam logic [1:0] SLOT_INVALID = 2'd3;
    // flash mode 3 behaves like none but keeps the attention colour
    localparam logic [1:0] FLASH_PLAIN  = 2'd3;

    localparam int RANDOM_ITEMS = 700;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_OFF     = 600;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic        func;
        logic [1:0]  slot;
        logic [23:0] colour;
        logic [1:0]  mode;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
    } t_led_req;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] owner;
        logic       blinking;
        logic       status;
    } t_led_view;

    typedef struct {
        t_led_req  req;
        bit        typed;
        t_led_view want;
    } t_led_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // slot[1:0], color[25:2], flash_mode[27:26], on_ms[43:28], off_ms[59:44]
    logic [63:0] s_axis_tdata = '0;
    // func[0]
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // red[7:0], green[15:8], blue[23:16], shown_slot[25:24], blinking[26]
    logic [31:0] m_axis_tdata;
    // status[0]
    logic [0:0]  m_axis_tuser;

    priority_led_blink_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // controller copy
    logic [23:0] slot_rgb [3];
    logic [15:0] slot_on [3];
    logic [15:0] slot_off [3];
    logic [1:0]  owner = plc_pkg::NO_OWNER;
    logic        blink_run = 1'b0;
    logic        lit_phase = 1'b0;
    logic [15:0] phase_ms = '0;
    logic [23:0] blink_rgb = '0;
    logic [15:0] blink_on_ms = '0;
    logic [15:0] blink_off_ms = '0;

    t_led_view shown_q[$];
    t_led_row  table_q[$];
    int        mismatches = 0;
    int        calm = 0;

    initial begin
        for (int i = 0; i < 3; i++) begin
            slot_rgb[i] = '0;
            slot_on[i]  = '0;
            slot_off[i] = '0;
        end
    end

    // restart the display on slot s, or go dark when s is NO_OWNER
    task automatic restart_display(input logic [1:0] s);
        logic [23:0] c;
        logic [15:0] on_t;
        logic [15:0] off_t;
        c = '0;
        on_t = '0;
        off_t = '0;
        if (s != plc_pkg::NO_OWNER) begin
            c = slot_rgb[s];
            on_t = slot_on[s];
            off_t = slot_off[s];
        end
        phase_ms = '0;
        if (c != 0 && on_t != 0 && off_t != 0) begin
            blink_run = 1'b1;
            lit_phase = 1'b1;
            blink_rgb = c;
            blink_on_ms = on_t;
            blink_off_ms = off_t;
        end else begin
            blink_run = 1'b0;
            lit_phase = 1'b0;
        end
    endtask

    task automatic predict_led(input t_led_req r, output t_led_view v);
        logic [23:0] c;
        logic [15:0] len;
        logic        timed;
        logic [1:0]  pick;
        v.status = plc_pkg::STATUS_OK;
        if (r.func == plc_pkg::FUNC_TICK) begin
            if (blink_run) begin
                len = lit_phase ? blink_on_ms : blink_off_ms;
                phase_ms = phase_ms + 16'd1;
                if (phase_ms >= len) begin
                    lit_phase = ~lit_phase;
                    phase_ms = '0;
                end
            end
        end else if (r.slot == SLOT_INVALID) begin
            v.status = plc_pkg::STATUS_BAD_SLOT;
        end else begin
            c = r.colour;
            timed = (r.mode == plc_pkg::FLASH_TIMED || r.mode == plc_pkg::FLASH_HW);
            if (r.slot == SLOT_ATTN) begin
                if (r.mode == plc_pkg::FLASH_NONE)
                    c = '0;
                else if (r.mode == plc_pkg::FLASH_HW && r.on_ms != 0 && r.off_ms == 0)
                    timed = 1'b0;
            end
            slot_rgb[r.slot] = c;
            slot_on[r.slot]  = timed ? r.on_ms : 16'd0;
            slot_off[r.slot] = timed ? r.off_ms : 16'd0;
            if (c != 0) begin
                if (owner == plc_pkg::NO_OWNER || r.slot >= owner) begin
                    restart_display(r.slot);
                    owner = r.slot;
                end
            end else if (r.slot == owner) begin
                // fall back to the highest lit slot below
                pick = plc_pkg::NO_OWNER;
                for (int i = int'(r.slot) - 1; i >= 0; i--)
                    if (pick == plc_pkg::NO_OWNER && slot_rgb[i] != 0)
                        pick = 2'(i);
                restart_display(pick);
                owner = pick;
            end
        end
        if (blink_run)
            c = lit_phase ? blink_rgb : 24'd0;
        else if (owner != plc_pkg::NO_OWNER)
            c = slot_rgb[owner];
        else
            c = '0;
        v.red = c[23:16];
        v.green = c[15:8];
        v.blue = c[7:0];
        v.owner = owner;
        v.blinking = blink_run;
    endtask

    function automatic t_led_req make_req(logic f, logic [1:0] s, logic [23:0] c,
                                          logic [1:0] m, logic [15:0] on_t,
                                          logic [15:0] off_t);
        t_led_req r;
        r.func = f;
        r.slot = s;
        r.colour = c;
        r.mode = m;
        r.on_ms = on_t;
        r.off_ms = off_t;
        return r;
    endfunction

    task automatic add_step(input t_led_req r);
        t_led_row row;
        row.req = r;
        row.typed = 1'b0;
        row.want = '{default: '0};
        table_q.push_back(row);
    endtask

    task automatic add_step_exp(input t_led_req r, input logic [23:0] c,
                                input logic [1:0] o, input logic b, input logic st);
        t_led_row row;
        row.req = r;
        row.typed = 1'b1;
        row.want.red = c[23:16];
        row.want.green = c[15:8];
        row.want.blue = c[7:0];
        row.want.owner = o;
        row.want.blinking = b;
        row.want.status = st;
        table_q.push_back(row);
    endtask

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        if (k < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic logic [15:0] random_ms();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return 16'($urandom_range(0, 6));
        if (k < 8)
            return 16'($urandom);
        return (k == 8) ? 16'd0 : 16'hFFFF;
    endfunction

    function automatic t_led_req random_req();
        t_led_req r;
        int k;
        r.func = ($urandom_range(0, 99) < 55) ? plc_pkg::FUNC_TICK : plc_pkg::FUNC_SET;
        r.slot = ($urandom_range(0, 19) == 0) ? SLOT_INVALID : 2'($urandom_range(0, 2));
        k = $urandom_range(0, 9);
        if (k < 3)
            r.colour = '0;
        else if (k == 3)
            r.colour = 24'hFFFFFF;
        else
            r.colour = 24'($urandom);
        r.mode = 2'($urandom_range(0, 3));
        r.on_ms = random_ms();
        r.off_ms = random_ms();
        return r;
    endfunction

    // called just after a rising edge; returns at the edge of the transfer
    task automatic send_req(input t_led_row row);
        t_led_view pred;
        int gap;
        if (calm == 0 && $urandom_range(0, 19) == 0)
            calm = $urandom_range(10, 30);
        if (calm > 0) begin
            gap = 0;
            calm--;
        end else begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, row.req.off_ms, row.req.on_ms, row.req.mode,
                         row.req.colour, row.req.slot};
        s_axis_tuser <= row.req.func;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        predict_led(row.req, pred);
        shown_q.push_back(row.typed ? row.want : pred);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        $display("mismatch %0d: %s expected %0h, got %0h", mismatches, what, want, got);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_led_view got;
        t_led_view want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.red = m_axis_tdata[7:0];
            got.green = m_axis_tdata[15:8];
            got.blue = m_axis_tdata[23:16];
            got.owner = m_axis_tdata[25:24];
            got.blinking = m_axis_tdata[26];
            got.status = m_axis_tuser[0];
            if (shown_q.size() == 0) begin
                report_mismatch("unexpected result, tdata", '0, m_axis_tdata);
            end else begin
                want = shown_q.pop_front();
                if (got.red !== want.red)
                    report_mismatch("red", 32'(want.red), 32'(got.red));
                if (got.green !== want.green)
                    report_mismatch("green", 32'(want.green), 32'(got.green));
                if (got.blue !== want.blue)
                    report_mismatch("blue", 32'(want.blue), 32'(got.blue));
                if (got.owner !== want.owner)
                    report_mismatch("shown_slot", 32'(want.owner), 32'(got.owner));
                if (got.blinking !== want.blinking)
                    report_mismatch("blinking", 32'(want.blinking), 32'(got.blinking));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(got.status));
            end
        end
    end

    // output side: random ready with one long hold-off
    initial begin
        int hi;
        int lo;
        int n;
        n = 0;
        forever begin
            hi = $urandom_range(1, 30);
            @(posedge i_clk);
            m_axis_tready <= 1'b1;
            repeat (hi - 1) @(posedge i_clk);
            lo = (n == 30) ? HOLD_OFF : pick_gap();
            if (lo > 0) begin
                @(posedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (lo - 1) @(posedge i_clk);
            end
            n++;
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("priority_led_blink_controller regression: fail");
        $finish;
    end

    initial begin
        t_led_row row;

        add_step_exp(make_req(plc_pkg::FUNC_TICK, SLOT_BATTERY, 24'h0, plc_pkg::FLASH_NONE,
                              16'd0, 16'd0),
                     24'h0, plc_pkg::NO_OWNER, 1'b0, plc_pkg::STATUS_OK);
        add_step_exp(make_req(plc_pkg::FUNC_SET, SLOT_INVALID, 24'hFFFFFF, plc_pkg::FLASH_HW,
                              16'hFFFF, 16'hFFFF),
                     24'h0, plc_pkg::NO_OWNER, 1'b0, plc_pkg::STATUS_BAD_SLOT);
        add_step_exp(make_req(plc_pkg::FUNC_SET, SLOT_BATTERY, 24'h102030, plc_pkg::FLASH_NONE,
                              16'd9, 16'd9),
                     24'h102030, SLOT_BATTERY, 1'b0, plc_pkg::STATUS_OK);
        add_step_exp(make_req(plc_pkg::FUNC_SET, SLOT_NOTIFY, 24'hFFFFFF, plc_pkg::FLASH_TIMED,
                              16'd3, 16'd2),
                     24'hFFFFFF, SLOT_NOTIFY, 1'b1, plc_pkg::STATUS_OK);
        repeat (5)
            add_step(make_req(plc_pkg::FUNC_TICK, SLOT_BATTERY, 24'h0, plc_pkg::FLASH_NONE,
                              16'd0, 16'd0));
        // lower slot only stores
        add_step(make_req(plc_pkg::FUNC_SET, SLOT_BATTERY, 24'hABCDEF, plc_pkg::FLASH_TIMED,
                          16'd0, 16'd0));
        // attention in mode none loses its colour
        add_step(make_req(plc_pkg::FUNC_SET, SLOT_ATTN, 24'h123456, plc_pkg::FLASH_NONE,
                          16'd4, 16'd4));
        // hardware mode with zero off time shows steady
        add_step_exp(make_req(plc_pkg::FUNC_SET, SLOT_ATTN, 24'h00FF00, plc_pkg::FLASH_HW,
                              16'd5, 16'd0),
                     24'h00FF00, SLOT_ATTN, 1'b0, plc_pkg::STATUS_OK);
        add_step(make_req(plc_pkg::FUNC_SET, SLOT_ATTN, 24'h0000FF, FLASH_PLAIN, 16'd7, 16'd7));
        add_step_exp(make_req(plc_pkg::FUNC_SET, SLOT_ATTN, 24'hFFFFFF, plc_pkg::FLASH_TIMED,
                              16'hFFFF, 16'hFFFF),
                     24'hFFFFFF, SLOT_ATTN, 1'b1, plc_pkg::STATUS_OK);
        add_step(make_req(plc_pkg::FUNC_TICK, SLOT_INVALID, 24'hFFFFFF, FLASH_PLAIN, 16'hFFFF,
                          16'hFFFF));
        // clearing the shown slot walks down to the next lit one
        add_step(make_req(plc_pkg::FUNC_SET, SLOT_ATTN, 24'h0, plc_pkg::FLASH_TIMED,
                          16'd1, 16'd1));
        add_step(make_req(plc_pkg::FUNC_SET, SLOT_NOTIFY, 24'h0, plc_pkg::FLASH_NONE,
                          16'd0, 16'd0));
        add_step_exp(make_req(plc_pkg::FUNC_SET, SLOT_BATTERY, 24'h0, plc_pkg::FLASH_NONE,
                              16'd0, 16'd0),
                     24'h0, plc_pkg::NO_OWNER, 1'b0, plc_pkg::STATUS_OK);
        add_step(make_req(plc_pkg::FUNC_SET, SLOT_BATTERY, 24'h000001, plc_pkg::FLASH_TIMED,
                          16'd1, 16'd1));
        repeat (2)
            add_step(make_req(plc_pkg::FUNC_TICK, SLOT_BATTERY, 24'h0, plc_pkg::FLASH_NONE,
                              16'd0, 16'd0));
        add_step(make_req(plc_pkg::FUNC_SET, SLOT_BATTERY, 24'h800000, plc_pkg::FLASH_TIMED,
                          16'd0, 16'd5));
        add_step(make_req(plc_pkg::FUNC_SET, SLOT_NOTIFY, 24'h0, plc_pkg::FLASH_HW,
                          16'hFFFF, 16'hFFFF));
        add_step(make_req(plc_pkg::FUNC_SET, SLOT_INVALID, 24'h0, plc_pkg::FLASH_NONE,
                          16'd0, 16'd0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_q[i])
            send_req(table_q[i]);
        row.typed = 1'b0;
        row.want = '{default: '0};
        repeat (RANDOM_ITEMS) begin
            row.req = random_req();
            send_req(row);
        end
        s_axis_tvalid <= 1'b0;

        while (shown_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("priority_led_blink_controller regression: pass");
        else
            $display("priority_led_blink_controller regression: fail");
        $finish;
    end

endmodule
